// File: src/msit_pkg.sv
// shared types and constants for the multi-slot interval timer
// no dependencies; imported by every other file of the block except msit_stream_if
package msit_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LEVEL_W    = 6;
    localparam int MASK_W     = 4;
    localparam int INTERVAL_W = 16;
    localparam int TIMEOUT_W  = 32;
    localparam int TOTAL_W    = 32;
    localparam int TO_IDX_W   = 2;

    localparam int PWM_MOD       = 63;
    localparam int INTERVAL_REGS = 4;
    localparam int TIMEOUT_MAX   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_BACKLIGHT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_USED     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_HALT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_BASE = 3'd3;

    localparam logic MODE_FAST_TICK = 1'b0;
    localparam logic MODE_LOAD      = 1'b1;

    typedef struct packed {
        logic                 mode;
        logic [TO_IDX_W-1:0]  timeout_index;
        logic [TIMEOUT_W-1:0] timeout_value;
    } item_t;

    typedef struct packed {
        logic               backlight_on;
        logic               slow_tick;
        logic [MASK_W-1:0]  fired_mask;
        logic [MASK_W-1:0]  timeout_active_mask;
        logic [TOTAL_W-1:0] slow_tick_total;
    } result_t;

    typedef struct packed {
        logic fast_step;
        logic slow_step;
        logic load_step;
    } tick_ctrl_t;

endpackage

// File: src/msit_stream_if.sv
// valid/ready stream interface carrying one payload per transaction
// payload type is set at instantiation, usually a type from msit_pkg
interface msit_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: src/msit_pwm.sv
// backlight pwm: modulo-63 accumulator and held output level
// depends on msit_pkg
module msit_pwm (
    input  logic                        clk,
    input  logic                        rst_n,
    input  msit_pkg::tick_ctrl_t        tick,
    input  logic [msit_pkg::LEVEL_W-1:0] level,
    output logic                        backlight_on
);
    import msit_pkg::*;

    logic [LEVEL_W-1:0] accum_reg;
    logic [LEVEL_W-1:0] accum_next;
    logic               bl_reg;
    logic [LEVEL_W:0]   sum;
    logic               wrap;

    always_comb
    begin
        sum        = {1'b0, accum_reg} + {1'b0, level};
        wrap       = sum >= (LEVEL_W+1)'(PWM_MOD);
        accum_next = wrap ? LEVEL_W'(sum - (LEVEL_W+1)'(PWM_MOD)) : sum[LEVEL_W-1:0];
        backlight_on = tick.fast_step ? wrap : bl_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg <= '0;
            bl_reg    <= 1'b0;
        end
        else if (tick.fast_step)
        begin
            accum_reg <= accum_next;
            bl_reg    <= wrap;
        end
    end
endmodule

// File: src/msit_prescaler.sv
// fast-tick prescaler and wrapping slow-tick total
// depends on msit_pkg
module msit_prescaler #(
    parameter int PRESCALE = 20
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  msit_pkg::tick_ctrl_t         tick,
    output logic                         slow_due,
    output logic [msit_pkg::TOTAL_W-1:0] total_next
);
    import msit_pkg::*;

    localparam int PW = $clog2(PRESCALE + 1);

    logic [PW-1:0]      count_reg;
    logic [PW-1:0]      count_dec;
    logic [TOTAL_W-1:0] total_reg;

    always_comb
    begin
        count_dec  = count_reg - PW'(1);
        slow_due   = count_dec == '0;
        total_next = tick.slow_step ? total_reg + TOTAL_W'(1) : total_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= PW'(PRESCALE);
            total_reg <= '0;
        end
        else
        begin
            if (tick.fast_step)
                count_reg <= slow_due ? PW'(PRESCALE) : count_dec;
            total_reg <= total_next;
        end
    end
endmodule

// File: src/msit_slots.sv
// interval slots: count slow ticks and fire at the programmed interval
// depends on msit_pkg
module msit_slots #(
    parameter int SLOT_COUNT = 4
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  msit_pkg::tick_ctrl_t                         tick,
    input  logic [msit_pkg::MASK_W-1:0]                  used_mask,
    input  logic [msit_pkg::MASK_W-1:0]                  halt_mask,
    input  logic [SLOT_COUNT-1:0][msit_pkg::INTERVAL_W-1:0] interval,
    output logic [msit_pkg::MASK_W-1:0]                  fired_mask
);
    import msit_pkg::*;

    logic [SLOT_COUNT-1:0][INTERVAL_W-1:0] count_reg;
    logic [SLOT_COUNT-1:0][INTERVAL_W-1:0] count_next;
    logic [INTERVAL_W-1:0]                 inc;
    logic                                  run;
    logic                                  hit;

    always_comb
    begin
        count_next = count_reg;
        fired_mask = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            run = used_mask[i] && !halt_mask[i];
            inc = count_reg[i] + INTERVAL_W'(1);
            hit = inc >= interval[i];
            if (tick.slow_step && run)
            begin
                count_next[i] = hit ? '0 : inc;
                fired_mask[i] = hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else
            count_reg <= count_next;
    end
endmodule

// File: src/msit_timeouts.sv
// one-shot timeouts: armed by load transactions, counted down on slow ticks
// depends on msit_pkg
module msit_timeouts #(
    parameter int TO_COUNT = 4
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  msit_pkg::tick_ctrl_t           tick,
    input  logic [msit_pkg::TO_IDX_W-1:0]  load_index,
    input  logic [msit_pkg::TIMEOUT_W-1:0] load_value,
    output logic [msit_pkg::MASK_W-1:0]    active_mask
);
    import msit_pkg::*;

    logic [TO_COUNT-1:0][TIMEOUT_W-1:0] count_reg;
    logic [TO_COUNT-1:0][TIMEOUT_W-1:0] count_next;
    logic [TO_COUNT-1:0]                armed_reg;
    logic [TO_COUNT-1:0]                armed_next;

    always_comb
    begin
        count_next = count_reg;
        armed_next = armed_reg;
        for (int i = 0; i < TO_COUNT; i++)
        begin
            if (tick.load_step && load_index == TO_IDX_W'(i))
            begin
                count_next[i] = load_value;
                armed_next[i] = 1'b1;
            end
            else if (tick.slow_step && armed_reg[i])
            begin
                if (count_reg[i] != '0)
                    count_next[i] = count_reg[i] - TIMEOUT_W'(1);
                else
                    armed_next[i] = 1'b0;
            end
        end
        active_mask = MASK_W'(armed_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            armed_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            armed_reg <= armed_next;
        end
    end
endmodule

// File: src/multi_slot_interval_timer_with_pwm.sv
// multi-slot interval timer with backlight pwm, top level
// depends on msit_pkg, msit_stream_if, msit_pwm, msit_prescaler, msit_slots, msit_timeouts
//
// Takes one transaction per cycle while the result side is not stalled and returns
// exactly one result per transaction. A transaction is held in an input register;
// in the cycle it moves to the result register, the pwm accumulator, the prescaler,
// every slot counter and every timeout are all updated in parallel by short logic,
// so the throughput is one transaction per clock while the result side is not
// stalled. Fast tick transactions (mode 0) advance the pwm and the prescaler, and
// every PRESCALE fast ticks a slow tick steps the slots, the timeouts and the slow
// tick total. Load transactions (mode 1) arm one timeout. Configuration writes must
// be made only while no transaction is in flight; the block does not hold them back.
module multi_slot_interval_timer_with_pwm #(
    parameter int SLOTS    = 4,
    parameter int TIMEOUTS = 4,
    parameter int PRESCALE = 20
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [msit_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [msit_pkg::CFG_DATA_W-1:0] cfg_data,
    msit_stream_if.sink                     item,
    msit_stream_if.source                   result
);
    import msit_pkg::*;

    localparam int SLOT_COUNT = (SLOTS < INTERVAL_REGS) ? SLOTS : INTERVAL_REGS;
    localparam int TO_COUNT   = (TIMEOUTS < TIMEOUT_MAX) ? TIMEOUTS : TIMEOUT_MAX;

    logic [LEVEL_W-1:0]                    level_reg;
    logic [MASK_W-1:0]                     used_reg;
    logic [MASK_W-1:0]                     halt_reg;
    logic [SLOT_COUNT-1:0][INTERVAL_W-1:0] interval_reg;

    logic    item_valid_reg;
    item_t   item_reg;
    logic    res_valid_reg;
    result_t res_reg;
    result_t res_next;
    logic    advance;

    tick_ctrl_t         tick;
    logic               slow_due;
    logic               backlight_on;
    logic [TOTAL_W-1:0] total_next;
    logic [MASK_W-1:0]  fired_mask;
    logic [MASK_W-1:0]  active_mask;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg    <= '0;
            used_reg     <= '0;
            halt_reg     <= '0;
            interval_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BACKLIGHT: level_reg <= cfg_data[LEVEL_W-1:0];
                CFG_SLOT_USED: used_reg  <= cfg_data[MASK_W-1:0];
                CFG_SLOT_HALT: halt_reg  <= cfg_data[MASK_W-1:0];
                default:
                begin
                    for (int s = 0; s < SLOT_COUNT; s++)
                    begin
                        if (cfg_index == CFG_INTERVAL_BASE + CFG_IDX_W'(s))
                            interval_reg[s] <= cfg_data[INTERVAL_W-1:0];
                    end
                end
            endcase
        end
    end

    // handshake and pipeline control
    assign advance      = item_valid_reg && (!res_valid_reg || result.ready);
    assign item.ready   = !item_valid_reg || advance;
    assign result.valid = res_valid_reg;
    assign result.payload = res_reg;

    always_comb
    begin
        tick.fast_step = advance && (item_reg.mode == MODE_FAST_TICK);
        tick.load_step = advance && (item_reg.mode == MODE_LOAD);
        tick.slow_step = tick.fast_step && slow_due;
    end

    msit_pwm u_pwm (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (tick),
        .level        (level_reg),
        .backlight_on (backlight_on)
    );

    msit_prescaler #(
        .PRESCALE (PRESCALE)
    ) u_prescaler (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .slow_due   (slow_due),
        .total_next (total_next)
    );

    msit_slots #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_slots (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (tick),
        .used_mask  (used_reg),
        .halt_mask  (halt_reg),
        .interval   (interval_reg),
        .fired_mask (fired_mask)
    );

    msit_timeouts #(
        .TO_COUNT (TO_COUNT)
    ) u_timeouts (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (tick),
        .load_index  (item_reg.timeout_index),
        .load_value  (item_reg.timeout_value),
        .active_mask (active_mask)
    );

    always_comb
    begin
        res_next.backlight_on        = backlight_on;
        res_next.slow_tick           = tick.slow_step;
        res_next.fired_mask          = fired_mask;
        res_next.timeout_active_mask = active_mask;
        res_next.slow_tick_total     = total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (item.ready)
                item_valid_reg <= item.valid;
            if (advance)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
            item_reg <= item.payload;
        if (advance)
            res_reg <= res_next;
    end

    // load transactions never report a slow tick
    a_load_no_slow: assert property (@(posedge clk) disable iff (!rst_n)
        tick.load_step |=> (res_valid_reg && !res_reg.slow_tick))
        else $error("slow tick reported for a load transaction");

    // a slot only fires on a slow tick
    a_fire_on_slow: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && fired_mask != '0) |-> tick.slow_step)
        else $error("slot fired without a slow tick");

    // input stage only stalls while holding a transaction
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (item_valid_reg && res_valid_reg && !result.ready))
        else $error("input stalled without a pending result");

    // result reports the slow tick total as updated by the slow tick
    a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
        tick.slow_step |=> (res_reg.slow_tick_total == $past(total_next)))
        else $error("slow tick total mismatch");
endmodule
